// ----- rtl/utf8_stream_decoder_defines.svh -----
// Assertion macros of the UTF-8 stream decoder RTL, used by the core.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define U8DEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("u8dec assertion failed");

// Checked on every clock edge, reset included.
`define U8DEC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("u8dec assertion failed");

`else

`define U8DEC_ASSERT(lbl, prop)
`define U8DEC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/u8dec_pkg.sv -----
// Types and constants of the UTF-8 stream decoder.
package u8dec_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PendW   = 2;

  localparam logic [CpW-1:0] BomValue = 21'h00FEFF;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_CHAR    = 3'd0,
    ST_MISSING = 3'd1,
    ST_STRAY   = 3'd2,
    ST_BOM     = 3'd3,
    ST_TRUNC   = 3'd4
  } status_e;

  // One input beat
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             stream_end;
    logic             stream_start;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_e        status;
  } result_t;

endpackage

// ----- rtl/u8dec_in_reg.sv -----
// Input register stage of the UTF-8 stream decoder.
module u8dec_in_reg
  import u8dec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  input  logic  item_take_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Accept a new beat when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/u8dec_core.sv -----
// Decoder state and per-byte decode logic.
`include "utf8_stream_decoder_defines.svh"

module u8dec_core
  import u8dec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    fire_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   acc_q, acc_d;
  logic             emitted_q, emitted_d;
  logic             halted_q, halted_d;

  logic [ByteW-1:0] b;
  logic             err;
  status_e          err_st;

  assign b = item_i.data_byte;

  // Decode one item against the current state
  always_comb begin
    pend_d      = pend_q;
    acc_d       = acc_q;
    emitted_d   = emitted_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '{code_point: '0, status: ST_CHAR};
    err         = 1'b0;
    err_st      = ST_CHAR;

    // start mark clears everything first
    if (item_i.stream_start) begin
      pend_d    = '0;
      acc_d     = '0;
      emitted_d = 1'b0;
      halted_d  = 1'b0;
    end

    if (!halted_d) begin
      if (item_i.stream_end) begin
        if (pend_d != '0) begin
          err    = 1'b1;
          err_st = ST_TRUNC;
        end
      end else if (!b[7]) begin
        // ASCII
        if (pend_d != '0) begin
          err    = 1'b1;
          err_st = ST_MISSING;
        end else begin
          emitted_d   = 1'b1;
          res_valid_o = 1'b1;
          res_o       = '{code_point: {{(CpW-ByteW){1'b0}}, b}, status: ST_CHAR};
        end
      end else if (b[7:6] == 2'b10) begin
        // continuation
        if (pend_d == '0) begin
          err    = 1'b1;
          err_st = ST_STRAY;
        end else begin
          pend_d = pend_d - PendW'(1);
          acc_d  = {acc_d[CpW-7:0], b[5:0]};
          if (pend_d == '0) begin
            if (acc_d == BomValue) begin
              if (emitted_d) begin
                err    = 1'b1;
                err_st = ST_BOM;
              end
            end else begin
              emitted_d   = 1'b1;
              res_valid_o = 1'b1;
              res_o       = '{code_point: acc_d, status: ST_CHAR};
            end
          end
        end
      end else if (b[7:5] == 3'b110) begin
        pend_d = PendW'(1);
        acc_d  = {{(CpW-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        pend_d = PendW'(2);
        acc_d  = {{(CpW-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        pend_d = PendW'(3);
        acc_d  = {{(CpW-3){1'b0}}, b[2:0]};
      end
      // F8-FF fall through unchanged
    end

    // errors latch halted and report with a zero code point
    if (err) begin
      halted_d    = 1'b1;
      res_valid_o = 1'b1;
      res_o       = '{code_point: '0, status: err_st};
    end
  end

  // State moves only when the item is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      acc_q     <= '0;
      emitted_q <= 1'b0;
      halted_q  <= 1'b0;
    end else if (fire_i) begin
      pend_q    <= pend_d;
      acc_q     <= acc_d;
      emitted_q <= emitted_d;
      halted_q  <= halted_d;
    end
  end

  // Halted decoder stays silent until a start mark
  `U8DEC_ASSERT(a_halted_silent,
    fire_i && halted_q && !item_i.stream_start |-> !res_valid_o)
  // Any error result leaves the decoder halted
  `U8DEC_ASSERT(a_err_halts,
    fire_i && res_valid_o && (res_o.status != ST_CHAR) |=> halted_q)
  // Start plus end leaves nothing pending and no error
  `U8DEC_ASSERT(a_start_end_clean,
    fire_i && item_i.stream_start && item_i.stream_end |=> (pend_q == '0) && !halted_q)
  // State is clear in the cycle after reset is seen
  `U8DEC_ASSERT_ALWAYS(a_reset_clear,
    !rst_ni |=> (pend_q == '0) && !halted_q && !emitted_q)

endmodule

// ----- rtl/u8dec_out_reg.sv -----
// Result register of the UTF-8 stream decoder.
module u8dec_out_reg
  import u8dec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Room for a new result when empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder.
//
// Channel  Dir  tdata (low bit up)            tlast        tuser
// s_axis   in   data_byte[7:0]                stream_end   stream_start
// m_axis   out  code_point[20:0], 3'b0 pad    -            status[2:0]
//
// One byte per cycle sustained unless a stalled output holds a byte back;
// each beat is held in the input register, is decoded against the state
// registers and lands in the result register, from which it leaves when
// the output is ready.
// Bytes with no result pass through without touching the output side.
// Reset clears the stage valid bits and all decoder state.
// A stalled output holds back the input register only when the waiting
// byte produces a result.
module utf8_stream_decoder
  import u8dec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // stream_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // code_point[20:0], zero pad [23:21]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    fire;
  logic    res_valid;
  logic    out_free;
  result_t res;
  result_t out_res;

  assign in_item = '{data_byte: s_axis_tdata, stream_end: s_axis_tlast,
                     stream_start: s_axis_tuser};

  // Consume the held beat unless its result has nowhere to go
  assign fire = cur_valid && (!res_valid || out_free);

  u8dec_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (cur_valid),
    .item_take_i  (fire),
    .item_o       (cur_item)
  );

  u8dec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (cur_item),
    .fire_i      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  u8dec_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.code_point};
  assign m_axis_tuser = out_res.status;

endmodule
